// ===== rtl/core/e2g_pkg.sv =====
`default_nettype none

package e2g_pkg;

  // CORDIC depth, one pipeline stage per step (16 to 48)
  localparam int unsigned CORDIC_STAGES = 32;
  // square root digits: 2^60 down to 2^0, two bits a step
  localparam int unsigned SQRT_STEPS    = 31;
  localparam int unsigned MUL_LAT       = 3;

  localparam int unsigned IN_W   = 34;
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned VEC_W  = 54;
  localparam int unsigned ANG_W  = 34;
  localparam int unsigned ROT_W  = 34;
  localparam int unsigned MA_W   = 56;
  localparam int unsigned MB_W   = 33;
  localparam int unsigned MP_W   = 64;
  localparam int unsigned SQ_W   = 61;
  localparam int unsigned ROOT_W = 31;

  localparam logic signed [MB_W-1:0]  INVK_Q32 = 33'sd2608131496;
  localparam logic signed [MB_W-1:0]  BA_Q32   = 33'sd4280567084;
  localparam logic signed [MB_W-1:0]  E2_Q32   = 33'sd28752143;
  localparam logic signed [ROT_W-1:0] INVK_Q30 = 34'sd652032874;
  localparam logic signed [MA_W-1:0]  A_Q16    = 56'sd6378137000 <<< 16;
  localparam logic signed [MA_W-1:0]  EP2B_Q16 = 56'sd42841312 <<< 16;
  localparam logic signed [MA_W-1:0]  E2A_Q16  = 56'sd42697673 <<< 16;
  localparam logic signed [35:0]      B_MM     = 36'sd6356752314;
  localparam logic signed [ANG_W-1:0] QUARTER  = 34'sd1073741824;

  // pipeline positions, counted in register stages after the entry stage
  localparam int unsigned I_LON   = CORDIC_STAGES;
  localparam int unsigned I_P     = I_LON + MUL_LAT;
  localparam int unsigned I_U     = I_P + MUL_LAT;
  localparam int unsigned I_TH    = I_U + CORDIC_STAGES;
  localparam int unsigned I_CS    = I_TH + CORDIC_STAGES;
  localparam int unsigned I_SQ    = I_CS + MUL_LAT;
  localparam int unsigned I_CUBE  = I_SQ + MUL_LAT;
  localparam int unsigned I_ND    = I_CUBE + MUL_LAT;
  localparam int unsigned I_LATIN = I_ND + 1;
  localparam int unsigned I_LAT   = I_LATIN + CORDIC_STAGES;
  localparam int unsigned I_LATC  = I_LAT + 1;
  localparam int unsigned I_CSL   = I_LATC + CORDIC_STAGES;
  localparam int unsigned I_PZ    = I_CSL + MUL_LAT;
  localparam int unsigned I_SS2   = I_CSL + MUL_LAT;
  localparam int unsigned I_E     = I_SS2 + MUL_LAT;
  localparam int unsigned I_W     = I_E + 1;
  localparam int unsigned I_ROOT  = I_W + SQRT_STEPS;
  localparam int unsigned I_AR    = I_ROOT + MUL_LAT;
  // accept edge to the edge that takes the result
  localparam int unsigned LATENCY = I_AR + 3;

  typedef struct packed {
    logic signed [IN_W-1:0] pos_x;
    logic signed [IN_W-1:0] pos_y;
    logic signed [IN_W-1:0] pos_z;
    logic                   zero;
    logic                   polar;
  } item_t;

  // atan(2^-i), full circle = 2^32
  function automatic logic [31:0] atan_tab(input int unsigned i);
    logic [31:0] r;
    unique case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/e2g_front.sv =====
`default_nettype none

module e2g_front (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic signed [e2g_pkg::IN_W-1:0]       pos_x_i,
  input  wire logic signed [e2g_pkg::IN_W-1:0]       pos_y_i,
  input  wire logic signed [e2g_pkg::IN_W-1:0]       pos_z_i,
  output logic                                       busy_o,
  input  wire logic                                  pop_i,
  output logic                                       q_valid_o,
  output e2g_pkg::item_t                             q_item_o
);

  e2g_pkg::item_t slot_q [0:1];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           push, pop;
  e2g_pkg::item_t item;

  // classify: all-zero vector and polar axis
  always_comb begin
    item.pos_x = pos_x_i;
    item.pos_y = pos_y_i;
    item.pos_z = pos_z_i;
    item.zero  = (pos_x_i == '0) && (pos_y_i == '0) && (pos_z_i == '0);
    item.polar = (pos_x_i == '0) && (pos_y_i == '0) && (pos_z_i != '0);
  end

  assign busy_o    = cnt_q[1];
  assign push      = start_i && !busy_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign pop       = pop_i && q_valid_o;
  assign q_item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/e2g_mul.sv =====
`default_nettype none

// round(a*b / 2^s), half away from zero, s = 32 or 30; three stages
module e2g_mul (
  input  wire logic                                clk_i,
  input  wire logic signed [e2g_pkg::MA_W-1:0]     a_i,
  input  wire logic signed [e2g_pkg::MB_W-1:0]     b_i,
  input  wire logic                                shr32_i,
  output logic signed [e2g_pkg::MP_W-1:0]          p_o
);

  logic [e2g_pkg::MA_W-1:0] am_full;
  logic [e2g_pkg::MB_W-1:0] bm_full;
  logic [54:0]              am_q;
  logic [32:0]              bm_q;
  logic                     neg0_q, neg1_q, s0_q, s1_q;
  logic [64:0]              lo_q;
  logic [55:0]              hi_q;
  logic [88:0]              full, rnd;
  logic [58:0]              mag;

  assign am_full = a_i[e2g_pkg::MA_W-1] ? e2g_pkg::MA_W'(-a_i) : e2g_pkg::MA_W'(a_i);
  assign bm_full = b_i[e2g_pkg::MB_W-1] ? e2g_pkg::MB_W'(-b_i) : e2g_pkg::MB_W'(b_i);

  assign full = {1'b0, hi_q, 32'b0} + 89'(lo_q);
  assign rnd  = full + (s1_q ? (89'(1) << 31) : (89'(1) << 29));
  assign mag  = s1_q ? {2'b0, rnd[88:32]} : rnd[88:30];

  always_ff @(posedge clk_i) begin
    am_q   <= am_full[54:0];
    bm_q   <= bm_full;
    neg0_q <= a_i[e2g_pkg::MA_W-1] ^ b_i[e2g_pkg::MB_W-1];
    s0_q   <= shr32_i;
    lo_q   <= am_q[31:0] * bm_q;
    hi_q   <= am_q[54:32] * bm_q;
    neg1_q <= neg0_q;
    s1_q   <= s0_q;
    p_o    <= neg1_q ? -$signed(64'(mag)) : $signed(64'(mag));
  end

endmodule

`default_nettype wire

// ===== rtl/core/e2g_vec.sv =====
`default_nettype none

// vectoring CORDIC, one step a stage: angle of (x, y) and gain times magnitude
module e2g_vec (
  input  wire logic                                 clk_i,
  input  wire logic signed [e2g_pkg::VEC_W-1:0]     x_i,
  input  wire logic signed [e2g_pkg::VEC_W-1:0]     y_i,
  output logic signed [e2g_pkg::VEC_W-1:0]          x_o,
  output logic signed [e2g_pkg::ANG_W-1:0]          ang_o
);

  localparam int unsigned N = e2g_pkg::CORDIC_STAGES;

  logic signed [e2g_pkg::VEC_W-1:0] x_q [0:N-1];
  logic signed [e2g_pkg::VEC_W-1:0] y_q [0:N-1];
  logic signed [e2g_pkg::ANG_W-1:0] a_q [0:N-1];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [e2g_pkg::VEC_W-1:0] xs, ys;
    logic signed [e2g_pkg::ANG_W-1:0] angs, step;
    if (i == 0) begin : g_first
      assign xs   = x_i;
      assign ys   = y_i;
      assign angs = '0;
    end else begin : g_next
      assign xs   = x_q[i-1];
      assign ys   = y_q[i-1];
      assign angs = a_q[i-1];
    end
    assign step = $signed(e2g_pkg::ANG_W'(e2g_pkg::atan_tab(i)));
    always_ff @(posedge clk_i) begin
      if (!ys[e2g_pkg::VEC_W-1]) begin
        x_q[i] <= xs + (ys >>> i);
        y_q[i] <= ys - (xs >>> i);
        a_q[i] <= angs + step;
      end else begin
        x_q[i] <= xs - (ys >>> i);
        y_q[i] <= ys + (xs >>> i);
        a_q[i] <= angs - step;
      end
    end
  end

  assign x_o   = x_q[N-1];
  assign ang_o = a_q[N-1];

endmodule

`default_nettype wire

// ===== rtl/core/e2g_rot.sv =====
`default_nettype none

// rotation CORDIC: Q30 cosine and sine of a binary angle
module e2g_rot (
  input  wire logic                                 clk_i,
  input  wire logic signed [e2g_pkg::ANG_W-1:0]     ang_i,
  output logic signed [e2g_pkg::ROT_W-1:0]          cos_o,
  output logic signed [e2g_pkg::ROT_W-1:0]          sin_o
);

  localparam int unsigned N = e2g_pkg::CORDIC_STAGES;

  logic signed [e2g_pkg::ROT_W-1:0] x_q [0:N-1];
  logic signed [e2g_pkg::ROT_W-1:0] y_q [0:N-1];
  logic signed [e2g_pkg::ANG_W-1:0] a_q [0:N-1];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [e2g_pkg::ROT_W-1:0] xs, ys;
    logic signed [e2g_pkg::ANG_W-1:0] angs, step;
    if (i == 0) begin : g_first
      assign xs   = e2g_pkg::INVK_Q30;
      assign ys   = '0;
      assign angs = ang_i;
    end else begin : g_next
      assign xs   = x_q[i-1];
      assign ys   = y_q[i-1];
      assign angs = a_q[i-1];
    end
    assign step = $signed(e2g_pkg::ANG_W'(e2g_pkg::atan_tab(i)));
    always_ff @(posedge clk_i) begin
      if (!angs[e2g_pkg::ANG_W-1]) begin
        x_q[i] <= xs - (ys >>> i);
        y_q[i] <= ys + (xs >>> i);
        a_q[i] <= angs - step;
      end else begin
        x_q[i] <= xs + (ys >>> i);
        y_q[i] <= ys - (xs >>> i);
        a_q[i] <= angs + step;
      end
    end
  end

  assign cos_o = x_q[N-1];
  assign sin_o = y_q[N-1];

endmodule

`default_nettype wire

// ===== rtl/core/e2g_sqrt.sv =====
`default_nettype none

// integer square root, one result bit a stage
module e2g_sqrt (
  input  wire logic                             clk_i,
  input  wire logic [e2g_pkg::SQ_W-1:0]         v_i,
  output logic [e2g_pkg::ROOT_W-1:0]            root_o
);

  localparam int unsigned S = e2g_pkg::SQRT_STEPS;
  localparam int unsigned W = e2g_pkg::SQ_W;

  logic [W-1:0] v_q   [0:S-1];
  logic [W-1:0] res_q [0:S-1];

  for (genvar i = 0; i < S; i++) begin : g_stage
    logic [W-1:0] vs, rs, bitv;
    logic [W:0]   trial;
    if (i == 0) begin : g_first
      assign vs = v_i;
      assign rs = '0;
    end else begin : g_next
      assign vs = v_q[i-1];
      assign rs = res_q[i-1];
    end
    assign bitv  = W'(1) << (W - 1 - 2 * i);
    assign trial = {1'b0, rs} + {1'b0, bitv};
    always_ff @(posedge clk_i) begin
      if ({1'b0, vs} >= trial) begin
        v_q[i]   <= vs - trial[W-1:0];
        res_q[i] <= (rs >> 1) + bitv;
      end else begin
        v_q[i]   <= vs;
        res_q[i] <= rs >> 1;
      end
    end
  end

  assign root_o = res_q[S-1][e2g_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/e2g_back.sv =====
`default_nettype none

module e2g_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              q_valid_i,
  input  wire e2g_pkg::item_t                    q_item_i,
  output logic                                   ready_o,
  output logic                                   done_o,
  output logic signed [e2g_pkg::OUT_W-1:0]       latitude_o,
  output logic signed [e2g_pkg::OUT_W-1:0]       longitude_o,
  output logic signed [e2g_pkg::OUT_W-1:0]       height_mm_o,
  output logic                                   valid_res_o
);

  localparam int unsigned LAST = e2g_pkg::I_AR;
  localparam int unsigned VW   = e2g_pkg::VEC_W;
  localparam int unsigned AW   = e2g_pkg::MA_W;
  localparam int unsigned BW   = e2g_pkg::MB_W;
  localparam int unsigned PW   = e2g_pkg::MP_W;

  typedef struct packed {
    logic signed [e2g_pkg::IN_W-1:0] z;
    logic                            zero;
    logic                            polar;
    logic [31:0]                     lon;
    logic signed [VW-1:0]            p;
    logic                            ndz;
    logic signed [31:0]              lat;
    logic signed [AW-1:0]            hpz;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > 41'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -41'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  side_t sb_q  [0:LAST];
  side_t sb_d  [1:LAST];
  logic  vld_q [0:LAST];
  side_t sb_in;

  logic signed [VW-1:0] xa_q, ya_q;
  logic signed [49:0]   xs, ys;
  logic                 xneg;

  // never stalls: the pipeline always advances
  assign ready_o = 1'b1;

  // entry stage: scale to Q16 and fold into the right half-plane
  assign xs   = {q_item_i.pos_x, 16'b0};
  assign ys   = {q_item_i.pos_y, 16'b0};
  assign xneg = q_item_i.pos_x[e2g_pkg::IN_W-1];

  always_comb begin
    sb_in       = '0;
    sb_in.z     = q_item_i.pos_z;
    sb_in.zero  = q_item_i.zero;
    sb_in.polar = q_item_i.polar;
    sb_in.lon   = xneg ? 32'h8000_0000 : 32'h0;
  end

  always_ff @(posedge clk_i) begin
    xa_q    <= xneg ? -VW'(xs) : VW'(xs);
    ya_q    <= xneg ? -VW'(ys) : VW'(ys);
    sb_q[0] <= sb_in;
  end

  // longitude and gain-corrected p
  logic signed [VW-1:0]               xv;
  logic signed [e2g_pkg::ANG_W-1:0]   lon_ang;
  logic signed [PW-1:0]               p_full, u_full;

  e2g_vec u_vec_lon (.clk_i, .x_i(xa_q), .y_i(ya_q), .x_o(xv), .ang_o(lon_ang));
  e2g_mul u_mul_p (.clk_i, .a_i(AW'(xv)), .b_i(e2g_pkg::INVK_Q32), .shr32_i(1'b1),
                   .p_o(p_full));
  e2g_mul u_mul_u (.clk_i, .a_i(p_full[AW-1:0]), .b_i(e2g_pkg::BA_Q32), .shr32_i(1'b1),
                   .p_o(u_full));

  // parametric latitude theta and its cube terms
  logic signed [VW-1:0]               th_x;
  logic signed [e2g_pkg::ANG_W-1:0]   th_ang;
  logic signed [e2g_pkg::ROT_W-1:0]   ct, st;
  logic signed [e2g_pkg::ROT_W-1:0]   ct_q [0:2];
  logic signed [e2g_pkg::ROT_W-1:0]   st_q [0:2];
  logic signed [PW-1:0]               cc, ss, c3, s3, m_num, m_den;
  logic signed [VW-1:0]               z_u;

  assign z_u = VW'($signed({sb_q[e2g_pkg::I_U].z, 16'b0}));

  e2g_vec u_vec_th (.clk_i, .x_i(u_full[VW-1:0]), .y_i(z_u), .x_o(th_x), .ang_o(th_ang));
  e2g_rot u_rot_th (.clk_i, .ang_i(th_ang), .cos_o(ct), .sin_o(st));

  always_ff @(posedge clk_i) begin
    ct_q[0] <= ct;
    st_q[0] <= st;
    ct_q[1] <= ct_q[0];
    st_q[1] <= st_q[0];
    ct_q[2] <= ct_q[1];
    st_q[2] <= st_q[1];
  end

  e2g_mul u_mul_cc (.clk_i, .a_i(AW'(ct)), .b_i(ct[BW-1:0]), .shr32_i(1'b0), .p_o(cc));
  e2g_mul u_mul_ss (.clk_i, .a_i(AW'(st)), .b_i(st[BW-1:0]), .shr32_i(1'b0), .p_o(ss));
  e2g_mul u_mul_c3 (.clk_i, .a_i(cc[AW-1:0]), .b_i(ct_q[2][BW-1:0]), .shr32_i(1'b0),
                    .p_o(c3));
  e2g_mul u_mul_s3 (.clk_i, .a_i(ss[AW-1:0]), .b_i(st_q[2][BW-1:0]), .shr32_i(1'b0),
                    .p_o(s3));
  e2g_mul u_mul_num (.clk_i, .a_i(e2g_pkg::EP2B_Q16), .b_i(s3[BW-1:0]), .shr32_i(1'b0),
                     .p_o(m_num));
  e2g_mul u_mul_den (.clk_i, .a_i(e2g_pkg::E2A_Q16), .b_i(c3[BW-1:0]), .shr32_i(1'b0),
                     .p_o(m_den));

  // latitude numerator and denominator; clamp a negative denominator
  logic signed [VW-1:0] num, den_raw, den, num_q, den_q;
  logic                 ndz;

  assign num     = VW'($signed({sb_q[e2g_pkg::I_ND].z, 16'b0})) + m_num[VW-1:0];
  assign den_raw = sb_q[e2g_pkg::I_ND].p - m_den[VW-1:0];
  assign den     = den_raw[VW-1] ? '0 : den_raw;
  assign ndz     = (num == '0) && (den == '0);

  always_ff @(posedge clk_i) begin
    num_q <= num;
    den_q <= den;
  end

  logic signed [VW-1:0]             lat_x;
  logic signed [e2g_pkg::ANG_W-1:0] lat_ang;
  logic signed [31:0]               lat_new;

  e2g_vec u_vec_lat (.clk_i, .x_i(den_q), .y_i(num_q), .x_o(lat_x), .ang_o(lat_ang));

  always_comb begin
    if (sb_q[e2g_pkg::I_LAT].ndz) begin
      lat_new = '0;
    end else if (lat_ang > e2g_pkg::QUARTER) begin
      lat_new = e2g_pkg::QUARTER[31:0];
    end else if (lat_ang < -e2g_pkg::QUARTER) begin
      lat_new = -e2g_pkg::QUARTER[31:0];
    end else begin
      lat_new = lat_ang[31:0];
    end
  end

  // height: p cos lat + z sin lat - a sqrt(1 - e2 sin^2 lat)
  logic signed [e2g_pkg::ROT_W-1:0] cl, sl;
  logic signed [PW-1:0]             pc, zs, sl2, e_full, ar;
  logic signed [PW-1:0]             w_full;
  logic [e2g_pkg::SQ_W-1:0]         w_q;
  logic [e2g_pkg::ROOT_W-1:0]       root;

  e2g_rot u_rot_lat (.clk_i, .ang_i(e2g_pkg::ANG_W'(sb_q[e2g_pkg::I_LATC].lat)),
                     .cos_o(cl), .sin_o(sl));
  e2g_mul u_mul_pc (.clk_i, .a_i(AW'(sb_q[e2g_pkg::I_CSL].p)), .b_i(cl[BW-1:0]),
                    .shr32_i(1'b0), .p_o(pc));
  e2g_mul u_mul_zs (.clk_i, .a_i(AW'($signed({sb_q[e2g_pkg::I_CSL].z, 16'b0}))),
                    .b_i(sl[BW-1:0]), .shr32_i(1'b0), .p_o(zs));
  e2g_mul u_mul_sl2 (.clk_i, .a_i(AW'(sl)), .b_i(sl[BW-1:0]), .shr32_i(1'b0), .p_o(sl2));
  e2g_mul u_mul_e (.clk_i, .a_i(sl2[AW-1:0]), .b_i(e2g_pkg::E2_Q32), .shr32_i(1'b1),
                   .p_o(e_full));

  assign w_full = PW'(e2g_pkg::QUARTER) - e_full;

  always_ff @(posedge clk_i) begin
    w_q <= w_full[PW-1] ? '0 : {w_full[30:0], 30'b0};
  end

  e2g_sqrt u_sqrt (.clk_i, .v_i(w_q), .root_o(root));
  e2g_mul u_mul_ar (.clk_i, .a_i(e2g_pkg::A_Q16), .b_i({2'b0, root}), .shr32_i(1'b0),
                    .p_o(ar));

  // side line: carry flags and values that later stages need
  for (genvar k = 1; k <= LAST; k++) begin : g_side
    always_comb begin
      sb_d[k] = sb_q[k-1];
      if (k == e2g_pkg::I_LON + 1) begin
        sb_d[k].lon = sb_q[k-1].lon + lon_ang[31:0];
      end
      if (k == e2g_pkg::I_P + 1) begin
        sb_d[k].p = p_full[VW-1:0];
      end
      if (k == e2g_pkg::I_ND + 1) begin
        sb_d[k].ndz = ndz;
      end
      if (k == e2g_pkg::I_LAT + 1) begin
        sb_d[k].lat = lat_new;
      end
      if (k == e2g_pkg::I_PZ + 1) begin
        sb_d[k].hpz = pc[AW-1:0] + zs[AW-1:0];
      end
    end
    always_ff @(posedge clk_i) begin
      sb_q[k] <= sb_d[k];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= q_valid_i;
    end
  end

  // final: round Q16 to mm, saturate, and apply the special cases
  logic signed [AW:0]  h_full;
  logic signed [40:0]  h_mm;
  logic signed [35:0]  z36, zabs, hp;
  side_t               fin;

  assign fin    = sb_q[LAST];
  assign h_full = (AW+1)'(fin.hpz) - (AW+1)'(ar[AW-1:0]) + (AW+1)'(32768);
  assign h_mm   = 41'(h_full >>> 16);
  assign z36    = 36'(fin.z);
  assign zabs   = z36[35] ? -z36 : z36;
  assign hp     = zabs - e2g_pkg::B_MM;

  always_ff @(posedge clk_i) begin
    if (fin.zero) begin
      latitude_o  <= '0;
      longitude_o <= '0;
      height_mm_o <= '0;
    end else if (fin.polar) begin
      latitude_o  <= fin.z[e2g_pkg::IN_W-1] ? -e2g_pkg::QUARTER[31:0]
                                            : e2g_pkg::QUARTER[31:0];
      longitude_o <= '0;
      height_mm_o <= sat32(41'(hp));
    end else begin
      latitude_o  <= fin.lat;
      longitude_o <= fin.lon;
      height_mm_o <= sat32(h_mm);
    end
    valid_res_o <= !fin.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vld_q[LAST];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ecef_to_geodetic_converter.sv =====
`default_nettype none

// ECEF to WGS-84 geodetic converter, Bowring's method, one iteration.
// Input: raise start_i with pos_x_i/pos_y_i/pos_z_i (signed mm); the transfer
//   happens at the rising edge where start_i is high and busy_o is low.
// Output: done_o is high for one cycle with latitude_o, longitude_o
//   (binary angles, 2^31 = 180 degrees), height_mm_o (saturated) and
//   valid_res_o; the result is taken at the edge that ends that cycle.
// Structure: a front end classifies each item (all-zero vector, polar
//   axis) and places it in a two-entry queue; a fully pipelined back end
//   runs five CORDIC units, thirteen split multipliers and a pipelined
//   square root that settles one result bit a stage.
// Throughput: one item per cycle. The delay from the accepting edge to the
//   edge that takes the result grows with CORDIC_STAGES and is set by the
//   chain of CORDIC runs and the square root.
// The back end never stalls, so the queue never fills and busy_o stays low.
// The receiver cannot hold results off; none is needed since the pipeline
//   advances every cycle.
// Reset: clears the queue, the pipeline valid flags and done_o; items in flight are dropped.
module ecef_to_geodetic_converter (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic signed [e2g_pkg::IN_W-1:0]     pos_x_i,
  input  wire logic signed [e2g_pkg::IN_W-1:0]     pos_y_i,
  input  wire logic signed [e2g_pkg::IN_W-1:0]     pos_z_i,
  output logic                                     done_o,
  output logic signed [e2g_pkg::OUT_W-1:0]         latitude_o,
  output logic signed [e2g_pkg::OUT_W-1:0]         longitude_o,
  output logic signed [e2g_pkg::OUT_W-1:0]         height_mm_o,
  output logic                                     valid_res_o
);

  e2g_pkg::item_t q_item;
  logic           q_valid;
  logic           back_ready;

  // accept and classify, hold in the queue
  e2g_front u_front (
    .clk_i,
    .rst_ni,
    .start_i,
    .pos_x_i,
    .pos_y_i,
    .pos_z_i,
    .busy_o,
    .pop_i     (back_ready),
    .q_valid_o (q_valid),
    .q_item_o  (q_item)
  );

  // advance every item through the conversion pipeline
  e2g_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .ready_o   (back_ready),
    .done_o,
    .latitude_o,
    .longitude_o,
    .height_mm_o,
    .valid_res_o
  );

`ifndef SYNTHESIS
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("queue filled although the back end never stalls");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(e2g_pkg::LATENCY) done_o)
    else $error("result not delivered after the pipeline latency");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !valid_res_o) |->
      (latitude_o == '0 && longitude_o == '0 && height_mm_o == '0))
    else $error("zero vector result carries non-zero fields");

  a_lat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && valid_res_o) |->
      (latitude_o <= 32'sd1073741824 && latitude_o >= -32'sd1073741824))
    else $error("latitude outside +-90 degrees");
`endif

endmodule

`default_nettype wire
